// ===== rtl/core/tile_majority_class_vote_unit_assert.svh =====
// Assertion macros for the tile majority class vote unit.
`ifndef TILE_MAJORITY_CLASS_VOTE_UNIT_ASSERT_SVH
`define TILE_MAJORITY_CLASS_VOTE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define TMCV_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define TMCV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TMCV_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define TMCV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/core/tmcv_pkg.sv =====
// Shared types and constants of the tile majority class vote unit.
`default_nettype none

package tmcv_pkg;

   // Fixed field widths of the request, response and register words.
   localparam int COORD_W    = 12;
   localparam int CFG_W      = 10;
   localparam int CLASS_W    = 5;
   localparam int GRID_IDX_W = 4;
   localparam int COUNT_W    = 20;
   localparam int CSR_IDX_W  = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [CFG_W-1:0] TILE_SIZE_RESET = CFG_W'(64);

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_ACCUM = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_HEIGHT = CSR_IDX_W'(1);

   // Control sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOCATE,
      ST_BASE,
      ST_READ,
      ST_MODIFY,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/tmcv_tile_locator.sv =====
// Multi-cycle tile locator: divides pixel coordinates by the tile size.
`default_nettype none

module tmcv_tile_locator #(
   parameter int GRID_ROWS  = 9,
   parameter int GRID_COLS  = 9,
   parameter int COORD_BITS = 12,
   localparam int MaxGrid   = (GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS,
   localparam int QuotBits  = (MaxGrid > 1) ? $clog2(MaxGrid) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [tmcv_pkg::COORD_W-1:0]      pixel_x,
   input  wire logic [tmcv_pkg::COORD_W-1:0]      pixel_y,
   input  wire logic [tmcv_pkg::CFG_W-1:0]        tile_width,
   input  wire logic [tmcv_pkg::CFG_W-1:0]        tile_height,
   output logic                                   done,
   output logic                                   hit,
   output logic [QuotBits-1:0]                    row,
   output logic [QuotBits-1:0]                    col
);

   localparam int CmpW  = (tmcv_pkg::CFG_W + QuotBits > tmcv_pkg::COORD_W) ?
                          tmcv_pkg::CFG_W + QuotBits : tmcv_pkg::COORD_W;
   localparam int StepW = (QuotBits > 1) ? $clog2(QuotBits) : 1;
   localparam logic [tmcv_pkg::COORD_W-1:0] CoordMask =
      (COORD_BITS >= tmcv_pkg::COORD_W) ? {tmcv_pkg::COORD_W{1'b1}} :
      tmcv_pkg::COORD_W'((1 << COORD_BITS) - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                drop_ff, drop_in;
   logic [StepW-1:0]    step_ff, step_in;
   logic [CmpW-1:0]     rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [CmpW-1:0]     div_x_ff, div_x_in, div_y_ff, div_y_in;
   logic [QuotBits-1:0] qx_ff, qx_in, qy_ff, qy_in;

   logic [CmpW-1:0]     x_ext, y_ext, w_ext, h_ext;
   logic                ge_x, ge_y;

   // Coordinates masked to the configured width, operands widened for compares.
   assign x_ext = CmpW'(pixel_x & CoordMask);
   assign y_ext = CmpW'(pixel_y & CoordMask);
   assign w_ext = CmpW'(tile_width);
   assign h_ext = CmpW'(tile_height);
   assign ge_x  = (rem_x_ff >= div_x_ff);
   assign ge_y  = (rem_y_ff >= div_y_ff);

   // One restoring quotient bit per cycle for both axes.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      drop_in  = drop_ff;
      step_in  = step_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      div_x_in = div_x_ff;
      div_y_in = div_y_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      if (start) begin
         busy_in  = 1'b1;
         drop_in  = (tile_width == '0) || (tile_height == '0) ||
                    (x_ext >= (w_ext << QuotBits)) || (y_ext >= (h_ext << QuotBits));
         step_in  = StepW'(QuotBits - 1);
         rem_x_in = x_ext;
         rem_y_in = y_ext;
         div_x_in = w_ext << (QuotBits - 1);
         div_y_in = h_ext << (QuotBits - 1);
         qx_in    = '0;
         qy_in    = '0;
      end else if (busy_ff) begin
         rem_x_in = ge_x ? (rem_x_ff - div_x_ff) : rem_x_ff;
         rem_y_in = ge_y ? (rem_y_ff - div_y_ff) : rem_y_ff;
         div_x_in = div_x_ff >> 1;
         div_y_in = div_y_ff >> 1;
         qx_in    = QuotBits'({qx_ff, ge_x});
         qy_in    = QuotBits'({qy_ff, ge_y});
         step_in  = step_ff - StepW'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         drop_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         drop_ff <= drop_in;
      end
      step_ff  <= step_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      div_x_ff <= div_x_in;
      div_y_ff <= div_y_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
   end

   // The tile is on the grid when nothing dropped it and both indexes fit.
   assign done = done_ff;
   assign hit  = !drop_ff && (int'(qy_ff) < GRID_ROWS) && (int'(qx_ff) < GRID_COLS);
   assign row  = qy_ff;
   assign col  = qx_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tmcv_vote_ram.sv =====
// Vote counter memory: one write port, one read port with registered data.
`default_nettype none

module tmcv_vote_ram #(
   parameter int DEPTH = 2106,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [AddrW-1:0]                  wr_addr,
   input  wire logic [tmcv_pkg::COUNT_W-1:0]      wr_data,
   input  wire logic                              rd_en,
   input  wire logic [AddrW-1:0]                  rd_addr,
   output logic [tmcv_pkg::COUNT_W-1:0]           rd_data
);

   logic [tmcv_pkg::COUNT_W-1:0] mem [DEPTH];
   logic [tmcv_pkg::COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tile_majority_class_vote_unit.sv =====
// Top level: per-tile class vote counters with accumulate, query and clear words.
// Accumulate: divider steps locate the tile, then a read-modify-write of its counter.
// Query: base, class counter scan and drain states, then result; an off-grid query skips to result.
// Clear: one counter written per cycle until the whole store is zero.
// One request word is in flight at a time; a finished response waits in an output register.
// After reset the store is swept to zero first.
`default_nettype none

module tile_majority_class_vote_unit #(
   parameter int GRID_ROWS   = 9,
   parameter int GRID_COLS   = 9,
   parameter int NUM_CLASSES = 26,
   parameter int COORD_BITS  = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel.
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_opcode,
   input  wire logic [tmcv_pkg::COORD_W-1:0]         req_pixel_x,
   input  wire logic [tmcv_pkg::COORD_W-1:0]         req_pixel_y,
   input  wire logic [tmcv_pkg::CLASS_W-1:0]         req_pixel_class,
   input  wire logic [tmcv_pkg::GRID_IDX_W-1:0]      req_query_row,
   input  wire logic [tmcv_pkg::GRID_IDX_W-1:0]      req_query_col,
   // Response channel.
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [tmcv_pkg::GRID_IDX_W-1:0]           rsp_tile_row,
   output logic [tmcv_pkg::GRID_IDX_W-1:0]           rsp_tile_col,
   output logic [tmcv_pkg::CLASS_W-1:0]              rsp_winning_class,
   output logic [tmcv_pkg::COUNT_W-1:0]              rsp_winning_count,
   // Configuration channel.
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tmcv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tmcv_pkg::CFG_W-1:0]           csr_wdata
);

`include "tile_majority_class_vote_unit_assert.svh"

   localparam int MaxGrid  = (GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS;
   localparam int QuotBits = (MaxGrid > 1) ? $clog2(MaxGrid) : 1;
   localparam int NumTiles = GRID_ROWS * GRID_COLS;
   localparam int TileW    = (NumTiles > 1) ? $clog2(NumTiles) : 1;
   localparam int Depth    = NumTiles * NUM_CLASSES;
   localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int ClsW     = $clog2(NUM_CLASSES);

   tmcv_pkg::state_type  state_ff, state_in;
   tmcv_pkg::opcode_type op_ff, op_in;
   tmcv_pkg::opcode_type req_op;

   logic [tmcv_pkg::CFG_W-1:0]      tile_width_ff, tile_height_ff;
   logic [ClsW-1:0]                 cls_ff, cls_in;
   logic [TileW-1:0]                tile_ff, tile_in;
   logic [AddrW-1:0]                base_ff, base_in;
   logic [AddrW-1:0]                acc_addr_ff, acc_addr_in;
   logic [AddrW-1:0]                clr_addr_ff, clr_addr_in;
   logic [ClsW-1:0]                 scan_k_ff, scan_k_in;
   logic                            pend_ff, pend_in;
   logic [ClsW-1:0]                 pend_cls_ff, pend_cls_in;
   logic [ClsW-1:0]                 best_cls_ff, best_cls_in;
   logic [tmcv_pkg::COUNT_W-1:0]    best_cnt_ff, best_cnt_in;
   logic [tmcv_pkg::GRID_IDX_W-1:0] qr_ff, qr_in, qc_ff, qc_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tmcv_pkg::GRID_IDX_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [tmcv_pkg::CLASS_W-1:0]    rsp_cls_ff, rsp_cls_in;
   logic [tmcv_pkg::COUNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;

   logic                            req_accept;
   logic                            cls_ok;
   logic                            query_on_grid;
   logic                            loc_start, loc_done, loc_hit;
   logic [QuotBits-1:0]             loc_row, loc_col;
   logic                            rsp_free;
   logic                            wr_en, rd_en;
   logic [AddrW-1:0]                wr_addr, rd_addr;
   logic [tmcv_pkg::COUNT_W-1:0]    wr_data, rd_data;

   assign req_op        = tmcv_pkg::opcode_type'(req_opcode);
   assign req_stall     = (state_ff != tmcv_pkg::ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign cls_ok        = (req_pixel_class != '0) && (int'(req_pixel_class) < NUM_CLASSES);
   assign query_on_grid = (int'(req_query_row) < GRID_ROWS) &&
                          (int'(req_query_col) < GRID_COLS);
   assign loc_start     = req_accept && (req_op == tmcv_pkg::OP_ACCUM) && cls_ok;
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;

   // Coordinate to tile division.
   tmcv_tile_locator #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS),
      .COORD_BITS(COORD_BITS)
   ) u_locator (
      .clock      (clock),
      .reset      (reset),
      .start      (loc_start),
      .pixel_x    (req_pixel_x),
      .pixel_y    (req_pixel_y),
      .tile_width (tile_width_ff),
      .tile_height(tile_height_ff),
      .done       (loc_done),
      .hit        (loc_hit),
      .row        (loc_row),
      .col        (loc_col)
   );

   // Counter store.
   tmcv_vote_ram #(
      .DEPTH(Depth)
   ) u_vote_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmcv_pkg::ST_CLEAR: begin
            if (clr_addr_ff == AddrW'(Depth - 1)) begin
               state_in = tmcv_pkg::ST_IDLE;
            end
         end
         tmcv_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  tmcv_pkg::OP_ACCUM: begin
                     if (cls_ok) begin
                        state_in = tmcv_pkg::ST_LOCATE;
                     end
                  end
                  tmcv_pkg::OP_QUERY: begin
                     state_in = query_on_grid ? tmcv_pkg::ST_BASE : tmcv_pkg::ST_RESULT;
                  end
                  tmcv_pkg::OP_CLEAR: state_in = tmcv_pkg::ST_CLEAR;
                  default:            state_in = tmcv_pkg::ST_IDLE;
               endcase
            end
         end
         tmcv_pkg::ST_LOCATE: begin
            if (loc_done) begin
               state_in = loc_hit ? tmcv_pkg::ST_BASE : tmcv_pkg::ST_IDLE;
            end
         end
         tmcv_pkg::ST_BASE: begin
            state_in = (op_ff == tmcv_pkg::OP_QUERY) ? tmcv_pkg::ST_SCAN : tmcv_pkg::ST_READ;
         end
         tmcv_pkg::ST_READ:   state_in = tmcv_pkg::ST_MODIFY;
         tmcv_pkg::ST_MODIFY: state_in = tmcv_pkg::ST_IDLE;
         tmcv_pkg::ST_SCAN: begin
            if (scan_k_ff == ClsW'(NUM_CLASSES - 1)) begin
               state_in = tmcv_pkg::ST_DRAIN;
            end
         end
         tmcv_pkg::ST_DRAIN:  state_in = tmcv_pkg::ST_RESULT;
         tmcv_pkg::ST_RESULT: begin
            if (rsp_free) begin
               state_in = tmcv_pkg::ST_IDLE;
            end
         end
         default: state_in = tmcv_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory controls per state.
   always_comb begin
      op_in        = op_ff;
      cls_in       = cls_ff;
      tile_in      = tile_ff;
      base_in      = base_ff;
      acc_addr_in  = acc_addr_ff;
      clr_addr_in  = clr_addr_ff;
      scan_k_in    = scan_k_ff;
      pend_in      = 1'b0;
      pend_cls_in  = scan_k_ff;
      best_cls_in  = best_cls_ff;
      best_cnt_in  = best_cnt_ff;
      qr_in        = qr_ff;
      qc_in        = qc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_cls_in   = rsp_cls_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = acc_addr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = base_ff + AddrW'(scan_k_ff);

      // A returned counter beats the best only when strictly larger, so ties keep the lower class.
      if (pend_ff && (rd_data > best_cnt_ff)) begin
         best_cnt_in = rd_data;
         best_cls_in = pend_cls_ff;
      end

      unique case (state_ff)
         tmcv_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + AddrW'(1);
         end
         tmcv_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in       = req_op;
               cls_in      = ClsW'(req_pixel_class);
               qr_in       = req_query_row;
               qc_in       = req_query_col;
               tile_in     = TileW'(int'(req_query_row) * GRID_COLS + int'(req_query_col));
               scan_k_in   = ClsW'(1);
               best_cls_in = '0;
               best_cnt_in = '0;
               clr_addr_in = '0;
            end
         end
         tmcv_pkg::ST_LOCATE: begin
            tile_in = TileW'(int'(loc_row) * GRID_COLS + int'(loc_col));
         end
         tmcv_pkg::ST_BASE: begin
            base_in = AddrW'(int'(tile_ff) * NUM_CLASSES);
         end
         tmcv_pkg::ST_READ: begin
            rd_en       = 1'b1;
            rd_addr     = base_ff + AddrW'(cls_ff);
            acc_addr_in = base_ff + AddrW'(cls_ff);
         end
         tmcv_pkg::ST_MODIFY: begin
            // Saturating increment of the counter read in the previous cycle.
            wr_en   = 1'b1;
            wr_addr = acc_addr_ff;
            wr_data = (rd_data == tmcv_pkg::COUNT_MAX) ? rd_data :
                      rd_data + tmcv_pkg::COUNT_W'(1);
         end
         tmcv_pkg::ST_SCAN: begin
            rd_en     = 1'b1;
            pend_in   = 1'b1;
            scan_k_in = scan_k_ff + ClsW'(1);
         end
         tmcv_pkg::ST_DRAIN: begin
            pend_in = 1'b0;
         end
         tmcv_pkg::ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = qr_ff;
               rsp_col_in   = qc_ff;
               rsp_cls_in   = tmcv_pkg::CLASS_W'(best_cls_ff);
               rsp_cnt_in   = best_cnt_ff;
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   // Configuration registers; the port always takes a word.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff  <= tmcv_pkg::TILE_SIZE_RESET;
         tile_height_ff <= tmcv_pkg::TILE_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tmcv_pkg::CSR_TILE_WIDTH:  tile_width_ff  <= csr_wdata;
            tmcv_pkg::CSR_TILE_HEIGHT: tile_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmcv_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      cls_ff      <= cls_in;
      tile_ff     <= tile_in;
      base_ff     <= base_in;
      acc_addr_ff <= acc_addr_in;
      scan_k_ff   <= scan_k_in;
      pend_cls_ff <= pend_cls_in;
      best_cls_ff <= best_cls_in;
      best_cnt_ff <= best_cnt_in;
      qr_ff       <= qr_in;
      qc_ff       <= qc_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_cls_ff  <= rsp_cls_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tile_row      = rsp_row_ff;
   assign rsp_tile_col      = rsp_col_ff;
   assign rsp_winning_class = rsp_cls_ff;
   assign rsp_winning_count = rsp_cnt_ff;

   // The write-back of an increment always follows the read of the same counter.
   `TMCV_ASSERT_SAME(a_modify_after_read, clock, reset, state_ff == tmcv_pkg::ST_MODIFY, $past(state_ff) == tmcv_pkg::ST_READ, "increment write without a preceding read")
   // The locator only finishes while the sequencer waits for it.
   `TMCV_ASSERT_SAME(a_locate_done, clock, reset, loc_done, state_ff == tmcv_pkg::ST_LOCATE, "locator finished outside the locate state")
   // A word with no votes names the background class.
   `TMCV_ASSERT_SAME(a_empty_is_background, clock, reset, rsp_valid_ff && (rsp_cnt_ff == '0), rsp_cls_ff == '0, "zero count with a nonzero class")
   // After a new response is loaded it is valid in the next cycle.
   `TMCV_ASSERT_NEXT(a_result_loads, clock, reset, (state_ff == tmcv_pkg::ST_RESULT) && rsp_free, rsp_valid_ff && (state_ff == tmcv_pkg::ST_IDLE), "response not loaded on leaving the result state")

endmodule

`default_nettype wire

// ===== verif/tb_tile_majority_class_vote_unit.sv =====
// Self-checking testbench for the tile majority class vote unit: directed table plus random phases.
module tb_tile_majority_class_vote_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_ROWS    = 9;
   localparam int GRID_COLS    = 9;
   localparam int NUM_CLASSES  = 26;
   localparam int COORD_BITS   = 12;
   localparam int CLK_PERIOD   = 8;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 156;
   // A clear sweeps the whole store, so this covers the slowest word in flight.
   localparam int DRAIN_CYCLES = GRID_ROWS * GRID_COLS * NUM_CLASSES + 64;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

   // Field widths shared with the block.
   localparam int COORD_W    = tmcv_pkg::COORD_W;
   localparam int CFG_W      = tmcv_pkg::CFG_W;
   localparam int CLASS_W    = tmcv_pkg::CLASS_W;
   localparam int GRID_IDX_W = tmcv_pkg::GRID_IDX_W;
   localparam int COUNT_W    = tmcv_pkg::COUNT_W;
   localparam int CSR_IDX_W  = tmcv_pkg::CSR_IDX_W;

   // Opcode and register index that the block must ignore.
   localparam logic [1:0]           OP_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);

   typedef struct {
      logic [1:0]            op;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [CLASS_W-1:0]    cls;
      logic [GRID_IDX_W-1:0] qr;
      logic [GRID_IDX_W-1:0] qc;
      bit                    typed;
      logic [CLASS_W-1:0]    w_cls;
      logic [COUNT_W-1:0]    w_cnt;
   } stim_row_type;

   typedef struct {
      logic [GRID_IDX_W-1:0] row;
      logic [GRID_IDX_W-1:0] col;
      logic [CLASS_W-1:0]    cls;
      logic [COUNT_W-1:0]    cnt;
   } tile_answer_type;

   logic clock;
   logic reset = 1'b1;

   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_opcode      = '0;
   logic [COORD_W-1:0]    req_pixel_x     = '0;
   logic [COORD_W-1:0]    req_pixel_y     = '0;
   logic [CLASS_W-1:0]    req_pixel_class = '0;
   logic [GRID_IDX_W-1:0] req_query_row   = '0;
   logic [GRID_IDX_W-1:0] req_query_col   = '0;

   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [GRID_IDX_W-1:0] rsp_tile_row;
   logic [GRID_IDX_W-1:0] rsp_tile_col;
   logic [CLASS_W-1:0]    rsp_winning_class;
   logic [COUNT_W-1:0]    rsp_winning_count;

   logic                  csr_valid       = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CFG_W-1:0]      csr_wdata       = '0;

   // Shadow copy of the vote store and the tile size registers.
   logic [COUNT_W-1:0] tally [GRID_ROWS][GRID_COLS][NUM_CLASSES];
   logic [CFG_W-1:0]   tile_w;
   logic [CFG_W-1:0]   tile_h;

   tile_answer_type pending_answers [$];
   stim_row_type    opening_rows [23];
   int              tw_plan [PHASES];
   int              th_plan [PHASES];

   int err_cnt    = 0;
   int checked    = 0;
   int votes_sent = 0;
   int query_sent = 0;
   int clear_sent = 0;
   int tx_quiet   = 0;
   int rx_quiet   = 0;
   int stall_left = 0;

   tile_majority_class_vote_unit #(
      .GRID_ROWS   (GRID_ROWS),
      .GRID_COLS   (GRID_COLS),
      .NUM_CLASSES (NUM_CLASSES),
      .COORD_BITS  (COORD_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_pixel_class   (req_pixel_class),
      .req_query_row     (req_query_row),
      .req_query_col     (req_query_col),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tile_row      (rsp_tile_row),
      .rsp_tile_col      (rsp_tile_col),
      .rsp_winning_class (rsp_winning_class),
      .rsp_winning_count (rsp_winning_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(CLK_PERIOD * 1_000_000);
      $display("** tile_majority_class_vote_unit: FAILED **");
      $finish;
   end

   // Idle length for one word: mostly random, with runs of back-to-back words.
   function automatic int draw_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         quiet = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic void tally_clear();
      foreach (tally[r, c, k]) tally[r][c][k] = '0;
   endfunction

   // One pixel vote: locate its tile, drop background, bad classes, off-grid pixels and zero tile sizes.
   function automatic void tally_vote(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                      logic [CLASS_W-1:0] cls);
      int r;
      int c;
      if (tile_w == '0 || tile_h == '0) return;
      if (cls == '0 || int'(cls) >= NUM_CLASSES) return;
      r = int'(y) / int'(tile_h);
      c = int'(x) / int'(tile_w);
      if (r >= GRID_ROWS || c >= GRID_COLS) return;
      if (tally[r][c][cls] != tmcv_pkg::COUNT_MAX) begin
         tally[r][c][cls] = tally[r][c][cls] + 1'b1;
      end
   endfunction

   // Winning class of a tile; the strict compare keeps the lower class on a tie.
   function automatic tile_answer_type tile_winner(logic [GRID_IDX_W-1:0] qr,
                                                   logic [GRID_IDX_W-1:0] qc);
      tile_answer_type a;
      a.row = qr;
      a.col = qc;
      a.cls = '0;
      a.cnt = '0;
      if (int'(qr) < GRID_ROWS && int'(qc) < GRID_COLS) begin
         for (int k = 1; k < NUM_CLASSES; k++) begin
            if (tally[qr][qc][k] > a.cnt) begin
               a.cnt = tally[qr][qc][k];
               a.cls = CLASS_W'(k);
            end
         end
      end
      return a;
   endfunction

   function automatic stim_row_type stim_row(logic [1:0] op, int x, int y, int cls, int qr,
                                             int qc, bit typed, int w_cls, int w_cnt);
      stim_row_type s;
      s.op    = op;
      s.x     = COORD_W'(x);
      s.y     = COORD_W'(y);
      s.cls   = CLASS_W'(cls);
      s.qr    = GRID_IDX_W'(qr);
      s.qc    = GRID_IDX_W'(qc);
      s.typed = typed;
      s.w_cls = CLASS_W'(w_cls);
      s.w_cnt = COUNT_W'(w_cnt);
      return s;
   endfunction

   // A coordinate inside a random grid cell for the given tile size, else a random one (zero size or past the range).
   function automatic logic [COORD_W-1:0] place(logic [CFG_W-1:0] size, int cells);
      int pos;
      if (size == '0) return COORD_W'($urandom_range(0, COORD_MAX));
      pos = $urandom_range(0, cells - 1) * int'(size) + $urandom_range(0, int'(size) - 1);
      if (pos > COORD_MAX) return COORD_W'($urandom_range(0, COORD_MAX));
      return COORD_W'(pos);
   endfunction

   // Random word: mostly in-grid votes over a few classes, with queries, noise and clears.
   function automatic stim_row_type make_item();
      stim_row_type s;
      int pick;
      pick = $urandom_range(0, 99);
      s = stim_row(tmcv_pkg::OP_ACCUM, $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, 31),
                   $urandom_range(0, 15), $urandom_range(0, 15), 1'b0, 0, 0);
      if (pick < 1) begin
         s.op = tmcv_pkg::OP_CLEAR;
      end else if (pick < 3) begin
         s.op = OP_UNUSED;
      end else if (pick < 27) begin
         s.op = tmcv_pkg::OP_QUERY;
         if ($urandom_range(0, 9) != 0) begin
            s.qr = GRID_IDX_W'($urandom_range(0, GRID_ROWS - 1));
            s.qc = GRID_IDX_W'($urandom_range(0, GRID_COLS - 1));
         end
      end else if (pick < 88) begin
         s.x   = place(tile_w, GRID_COLS);
         s.y   = place(tile_h, GRID_ROWS);
         s.cls = ($urandom_range(0, 9) < 6) ? CLASS_W'($urandom_range(1, 3))
                                            : CLASS_W'($urandom_range(1, NUM_CLASSES - 1));
      end
      return s;
   endfunction

   // Drive one request word and update the shadow store once it is taken.
   task automatic send_word(stim_row_type s);
      int gap;
      tile_answer_type a;
      gap = draw_gap(tx_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= s.op;
      req_pixel_x     <= s.x;
      req_pixel_y     <= s.y;
      req_pixel_class <= s.cls;
      req_query_row   <= s.qr;
      req_query_col   <= s.qc;
      do @(posedge clock); while (req_stall);
      case (s.op)
         tmcv_pkg::OP_ACCUM: begin
            tally_vote(s.x, s.y, s.cls);
            votes_sent++;
         end
         tmcv_pkg::OP_QUERY: begin
            a = tile_winner(s.qr, s.qc);
            if (s.typed) begin
               a.cls = s.w_cls;
               a.cnt = s.w_cnt;
            end
            pending_answers = {pending_answers, a};
            query_sent++;
         end
         tmcv_pkg::OP_CLEAR: begin
            tally_clear();
            clear_sent++;
         end
         default: ;
      endcase
   endtask

   // Hold requests until every answer is in and the last word has certainly finished.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; the port is idled again before the shadow registers are updated.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_W'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         tmcv_pkg::CSR_TILE_WIDTH:  tile_w = CFG_W'(val);
         tmcv_pkg::CSR_TILE_HEIGHT: tile_h = CFG_W'(val);
         default: ;
      endcase
   endtask

   // Response side: random stall per word, each answer checked against the oldest expectation.
   always @(posedge clock) begin : answer_sink
      tile_answer_type want;
      int hold;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("answer for tile (%0d,%0d) arrived with none expected",
                   rsp_tile_row, rsp_tile_col);
            err_cnt++;
         end else begin
            want = pending_answers.pop_front();
            checked++;
            if (rsp_tile_row !== want.row) begin
               $error("tile_row: expected %0d, got %0d", want.row, rsp_tile_row);
               err_cnt++;
            end
            if (rsp_tile_col !== want.col) begin
               $error("tile_col: expected %0d, got %0d", want.col, rsp_tile_col);
               err_cnt++;
            end
            if (rsp_winning_class !== want.cls) begin
               $error("winning_class: expected %0d, got %0d", want.cls, rsp_winning_class);
               err_cnt++;
            end
            if (rsp_winning_count !== want.cnt) begin
               $error("winning_count: expected %0d, got %0d", want.cnt, rsp_winning_count);
               err_cnt++;
            end
         end
         hold = draw_gap(rx_quiet);
         stall_left <= hold;
         rsp_stall  <= (hold != 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   initial begin : stimulus
      stim_row_type s;
      int counted;
      tally_clear();
      tile_w = tmcv_pkg::TILE_SIZE_RESET;
      tile_h = tmcv_pkg::TILE_SIZE_RESET;

      // Opening words at the reset tile size of 64 x 64.
      opening_rows = '{
         stim_row(tmcv_pkg::OP_QUERY,     0,    0,  0,  0,  0, 1'b1,  0, 0),
         stim_row(tmcv_pkg::OP_QUERY,     0,    0,  0,  8,  8, 1'b1,  0, 0),
         stim_row(tmcv_pkg::OP_QUERY,     0,    0,  0, 15, 15, 1'b1,  0, 0),
         stim_row(tmcv_pkg::OP_QUERY,     0,    0,  0,  9,  0, 1'b1,  0, 0),
         stim_row(tmcv_pkg::OP_ACCUM,     0,    0, 25,  0,  0, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_ACCUM,    63,   63,  1,  0,  0, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_QUERY,     0,    0,  0,  0,  0, 1'b1,  1, 1),
         stim_row(tmcv_pkg::OP_ACCUM,  4095, 4095,  3, 15, 15, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_ACCUM,   575,  575,  2,  0,  0, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_ACCUM,   576,    0,  2,  0,  0, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_QUERY,     0,    0,  0,  8,  8, 1'b1,  2, 1),
         stim_row(tmcv_pkg::OP_ACCUM,     0,    0,  0,  0,  0, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_ACCUM,     0,    0, 26,  0,  0, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_ACCUM,     0,    0, 31,  0,  0, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_ACCUM,     0,    0, 25,  0,  0, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_QUERY,     0,    0,  0,  0,  0, 1'b1, 25, 2),
         stim_row(OP_UNUSED,           4095, 4095, 31, 15, 15, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_QUERY,     0,    0,  0,  0,  8, 1'b1,  0, 0),
         stim_row(tmcv_pkg::OP_ACCUM,  4095,    0,  7,  0,  0, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_QUERY,     0,    0,  0,  0, 15, 1'b1,  0, 0),
         stim_row(tmcv_pkg::OP_CLEAR,     0,    0,  0,  0,  0, 1'b0,  0, 0),
         stim_row(tmcv_pkg::OP_QUERY,     0,    0,  0,  0,  0, 1'b1,  0, 0),
         stim_row(tmcv_pkg::OP_QUERY,     0,    0,  0,  8,  8, 1'b1,  0, 0)
      };

      // Tile size per phase: smallest, largest, each side zero, and a few mid values.
      tw_plan = '{1, 1023, 0, 64, $urandom_range(2, 1022), 5, $urandom_range(2, 1022), 1023};
      th_plan = '{1, 1023, 64, 0, $urandom_range(2, 1022), $urandom_range(2, 1022), 200, 1};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i]) send_word(opening_rows[i]);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         write_reg(tmcv_pkg::CSR_TILE_WIDTH, tw_plan[ph]);
         write_reg(tmcv_pkg::CSR_TILE_HEIGHT, th_plan[ph]);
         if (ph == 2) write_reg(CSR_UNUSED, $urandom_range(0, 1023));
         counted = 0;
         while (counted < PHASE_WORDS) begin
            // Now and then let every outstanding answer drain before the next word.
            if ($urandom_range(0, 59) == 0 && pending_answers.size() != 0) begin
               req_valid <= 1'b0;
               while (pending_answers.size() != 0) @(posedge clock);
            end
            s = make_item();
            send_word(s);
            if (s.op != OP_UNUSED) counted++;
         end
      end

      settle();
      $display("Sent %0d votes, %0d queries and %0d clears over %0d tile size settings.",
               votes_sent, query_sent, clear_sent, PHASES + 1);
      $display("Checked %0d tile answers field by field, %0d mismatches.", checked, err_cnt);
      if (err_cnt == 0) begin
         $display("** tile_majority_class_vote_unit: PASSED **");
      end else begin
         $display("** tile_majority_class_vote_unit: FAILED **");
      end
      $finish;
   end

endmodule
